>>> src/idll_pkg.sv
// ----------------------------------------------------------------------------
// idll_pkg
// Shared sizes, command and status codes, and the control and status bundles
// that join the list controller and its datapath.
// ----------------------------------------------------------------------------
package idll_pkg;

  localparam int POOL_ENTRIES = 64;
  localparam int VALUE_BITS   = 32;

  localparam int ADDR_W   = $clog2(POOL_ENTRIES);
  localparam int CNT_W    = $clog2(POOL_ENTRIES + 1);
  localparam int HANDLE_W = 6;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;
  localparam int OUT_W    = 32;

  localparam logic [CMD_W-1:0] CMD_INS_AFTER  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_BEFORE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ERASE      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic capture;   // latch the accepted item, start its link reads
    logic eval;      // decide, write node or unlink, latch the result
    logic link;      // second insert write: neighbors point at new node
    logic single;    // load the one result of a command
    logic step;      // load one dump result and advance the walk
    logic rd_input;  // read address comes from the input handle
  } ctl_t;

  typedef struct packed {
    logic ins_ok;
    logic dump_go;
    logic dump_last;
    logic out_free;
  } stat_t;

endpackage

>>> src/idll_ram.sv
// ----------------------------------------------------------------------------
// idll_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module idll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/idll_ctrl.sv
// ----------------------------------------------------------------------------
// idll_ctrl
// Command sequencer: accept, evaluate, link, respond, and walk the list on a
// dump one node per transfer.
// ----------------------------------------------------------------------------
module idll_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  idll_pkg::stat_t stat,
  output idll_pkg::ctl_t  ctl
);
  import idll_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_LINK,
    S_DUMP,
    S_RESP
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready     = !rst;
        ctl.rd_input = 1'b1;
        if (in_valid && !rst) begin
          ctl.capture = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        ctl.eval = 1'b1;
        if (stat.ins_ok) begin
          state_next = S_LINK;
        end else if (stat.dump_go) begin
          state_next = S_DUMP;
        end else begin
          state_next = S_RESP;
        end
      end
      S_LINK: begin
        ctl.link   = 1'b1;
        state_next = S_RESP;
      end
      S_DUMP: begin
        if (stat.out_free) begin
          ctl.step = 1'b1;
          if (stat.dump_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          ctl.single = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_accept_to_eval: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_EVAL))
    else $error("accepted item not evaluated next cycle");

  a_eval_after_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |-> ($past(state) == S_IDLE))
    else $error("evaluation entered without an accepted item");

  a_link_after_insert: assert property (@(posedge clk) disable iff (rst)
    (state == S_LINK) |-> $past(stat.ins_ok))
    else $error("link step without a valid insert");

endmodule

>>> src/idll_datapath.sv
// ----------------------------------------------------------------------------
// idll_datapath
// Link and value memories, head sentinel links, live flags, allocation count,
// dump walk pointer and the output register.
// ----------------------------------------------------------------------------
module idll_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [idll_pkg::CMD_W-1:0]          cmd,
  input  logic [idll_pkg::HANDLE_W-1:0]       handle,
  input  logic signed [31:0]                  item_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [idll_pkg::STATUS_W-1:0]       status,
  output logic [idll_pkg::HANDLE_W-1:0]       new_handle,
  output logic signed [idll_pkg::OUT_W-1:0]   out_value,
  output logic                                last,
  input  idll_pkg::ctl_t                      ctl,
  output idll_pkg::stat_t                     stat
);
  import idll_pkg::*;

  logic [CMD_W-1:0]        cmd_q;
  logic [HANDLE_W-1:0]     handle_q;
  logic signed [31:0]      value_q;

  logic [ADDR_W-1:0]       head_next;
  logic [ADDR_W-1:0]       head_prev;
  logic [POOL_ENTRIES-1:0] live;
  logic [CNT_W-1:0]        alloc;
  logic [ADDR_W-1:0]       cur;
  logic [ADDR_W-1:0]       walk_cnt;
  logic [ADDR_W-1:0]       link_a;
  logic [ADDR_W-1:0]       link_b;
  logic [STATUS_W-1:0]     res_status;
  logic [HANDLE_W-1:0]     res_handle;

  logic [ADDR_W-1:0]       rd_addr;
  logic [ADDR_W-1:0]       rd_next;
  logic [ADDR_W-1:0]       rd_prev;
  logic [VALUE_BITS-1:0]   rd_value;
  logic signed [VALUE_BITS-1:0] rd_value_s;

  logic                    next_we;
  logic [ADDR_W-1:0]       next_waddr;
  logic [ADDR_W-1:0]       next_wdata;
  logic                    prev_we;
  logic [ADDR_W-1:0]       prev_waddr;
  logic [ADDR_W-1:0]       prev_wdata;
  logic                    val_we;
  logic [VALUE_BITS-1:0]   val_wdata;

  logic                    in_pool;
  logic                    is_head;
  logic [ADDR_W-1:0]       h_idx;
  logic                    live_h;
  logic                    full;
  logic                    ins_cmd;
  logic                    target_ok;
  logic                    ins_ok;
  logic                    erase_ok;
  logic                    after;
  logic [ADDR_W-1:0]       h_next;
  logic [ADDR_W-1:0]       h_prev;
  logic [ADDR_W-1:0]       sel_a;
  logic [ADDR_W-1:0]       sel_b;
  logic [ADDR_W-1:0]       new_idx;
  logic                    dump_last;
  logic                    out_free;

  assign h_idx     = handle_q[ADDR_W-1:0];
  assign in_pool   = {1'b0, handle_q} < (HANDLE_W + 1)'(POOL_ENTRIES);
  assign is_head   = (handle_q == '0);
  assign live_h    = in_pool && live[h_idx];
  assign full      = (alloc >= CNT_W'(POOL_ENTRIES));
  assign ins_cmd   = (cmd_q == CMD_INS_AFTER) || (cmd_q == CMD_INS_BEFORE);
  assign after     = (cmd_q == CMD_INS_AFTER);
  assign target_ok = in_pool && (is_head || live_h);
  assign ins_ok    = ins_cmd && target_ok && !full;
  assign erase_ok  = (cmd_q == CMD_ERASE) && !is_head && live_h;
  assign new_idx   = alloc[ADDR_W-1:0];

  assign h_next = is_head ? head_next : rd_next;
  assign h_prev = is_head ? head_prev : rd_prev;
  assign sel_a  = (ins_cmd && after) ? h_idx : h_prev;
  assign sel_b  = (ins_cmd && !after) ? h_idx : h_next;

  assign dump_last = (rd_next == '0) || (walk_cnt == ADDR_W'(POOL_ENTRIES - 2));
  assign out_free  = !out_valid || out_ready;
  assign rd_value_s = rd_value;

  assign stat.ins_ok    = ins_ok;
  assign stat.dump_go   = (cmd_q == CMD_DUMP) && (head_next != '0);
  assign stat.dump_last = dump_last;
  assign stat.out_free  = out_free;

  always_comb begin
    if (ctl.rd_input) begin
      rd_addr = handle[ADDR_W-1:0];
    end else if (ctl.step) begin
      rd_addr = rd_next;
    end else begin
      rd_addr = cur;
    end
  end

  always_comb begin
    next_we    = 1'b0;
    next_waddr = sel_a;
    next_wdata = sel_b;
    prev_we    = 1'b0;
    prev_waddr = sel_b;
    prev_wdata = sel_a;
    val_we     = 1'b0;
    val_wdata  = VALUE_BITS'(value_q);
    if (ctl.eval && ins_ok) begin
      next_we    = 1'b1;
      next_waddr = new_idx;
      next_wdata = sel_b;
      prev_we    = 1'b1;
      prev_waddr = new_idx;
      prev_wdata = sel_a;
      val_we     = 1'b1;
    end else if (ctl.eval && erase_ok) begin
      next_we = (sel_a != '0);
      prev_we = (sel_b != '0);
    end else if (ctl.link) begin
      next_we    = (link_a != '0);
      next_waddr = link_a;
      next_wdata = new_idx;
      prev_we    = (link_b != '0);
      prev_waddr = link_b;
      prev_wdata = new_idx;
    end
  end

  idll_ram #(.WIDTH(ADDR_W), .DEPTH(POOL_ENTRIES)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (rd_addr),
    .rdata (rd_next)
  );

  idll_ram #(.WIDTH(ADDR_W), .DEPTH(POOL_ENTRIES)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (rd_addr),
    .rdata (rd_prev)
  );

  idll_ram #(.WIDTH(VALUE_BITS), .DEPTH(POOL_ENTRIES)) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (new_idx),
    .wdata (val_wdata),
    .raddr (rd_addr),
    .rdata (rd_value)
  );

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q    <= cmd;
      handle_q <= handle;
      value_q  <= item_value;
      cur      <= head_next;
      walk_cnt <= '0;
    end else if (ctl.step) begin
      cur      <= rd_next;
      walk_cnt <= walk_cnt + ADDR_W'(1);
    end
    if (ctl.eval) begin
      link_a     <= sel_a;
      link_b     <= sel_b;
      res_handle <= ins_ok ? HANDLE_W'(new_idx) : '0;
      case (cmd_q)
        CMD_INS_AFTER, CMD_INS_BEFORE: begin
          res_status <= !target_ok ? ST_BAD : (full ? ST_FULL : ST_OK);
        end
        CMD_ERASE: begin
          res_status <= erase_ok ? ST_OK : ST_BAD;
        end
        CMD_DUMP: begin
          res_status <= ST_EMPTY;
        end
        CMD_CLEAR: begin
          res_status <= ST_OK;
        end
        default: begin
          res_status <= ST_BAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (ctl.eval && (cmd_q == CMD_CLEAR))) begin
      head_next <= '0;
      head_prev <= '0;
      live      <= '0;
      alloc     <= CNT_W'(1);
    end else if (ctl.eval && ins_ok) begin
      live[new_idx] <= 1'b1;
    end else if (ctl.eval && erase_ok) begin
      live[h_idx] <= 1'b0;
      if (sel_a == '0) begin
        head_next <= sel_b;
      end
      if (sel_b == '0) begin
        head_prev <= sel_a;
      end
    end else if (ctl.link) begin
      alloc <= alloc + CNT_W'(1);
      if (link_a == '0) begin
        head_next <= new_idx;
      end
      if (link_b == '0) begin
        head_prev <= new_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.single || ctl.step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.single) begin
      status     <= res_status;
      new_handle <= res_handle;
      out_value  <= '0;
      last       <= 1'b1;
    end else if (ctl.step) begin
      status     <= ST_OK;
      new_handle <= '0;
      out_value  <= OUT_W'(rd_value_s);
      last       <= dump_last;
    end
  end

  a_head_links_agree: assert property (@(posedge clk) disable iff (rst)
    (head_next == '0) == (head_prev == '0))
    else $error("head links disagree on an empty list");

  a_alloc_range: assert property (@(posedge clk) disable iff (rst)
    (alloc != '0) && (alloc <= CNT_W'(POOL_ENTRIES)))
    else $error("allocation count out of range");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    (ctl.single || ctl.step) |-> out_free)
    else $error("output register overwritten before transfer");

endmodule

>>> src/indexed_doubly_linked_list.sv
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list
// Circular doubly linked list in a fixed node pool with head sentinel.
// ----------------------------------------------------------------------------
// Commands take one at a time. From input transfer to result in the output
// register: insert passes evaluate, link and respond; erase, clear, a
// rejected command and an empty dump pass evaluate and respond; a dump
// gives its first node after evaluate, then one node per cycle while
// out_ready stays high. Each link memory has one write port and a registered
// read, so an insert needs a read then two rounds of link writes, and the
// dump walk reads one next link per node. The next command is taken once
// the current one has loaded its last result. Head links are registers and
// nodes are written before any read, so no clearing pass follows reset or clear.
module indexed_doubly_linked_list (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [idll_pkg::CMD_W-1:0]        cmd,
  input  logic [idll_pkg::HANDLE_W-1:0]     handle,
  input  logic signed [31:0]                item_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [idll_pkg::STATUS_W-1:0]     status,
  output logic [idll_pkg::HANDLE_W-1:0]     new_handle,
  output logic signed [idll_pkg::OUT_W-1:0] out_value,
  output logic                              last
);
  import idll_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  idll_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  idll_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .handle     (handle),
    .item_value (item_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .new_handle (new_handle),
    .out_value  (out_value),
    .last       (last),
    .ctl        (ctl),
    .stat       (stat)
  );

endmodule
